// ===== rtl/core/sacl_pkg.sv =====
// Shared constants, register codes and handshake structs of the speed limiter.
`default_nettype none

package sacl_pkg;

    // fixed point format of speeds, accelerations and curvature
    localparam int FRAC_BITS   = 16;
    localparam int PERIOD_BITS = 16;

    localparam int SPD_W  = 32;              // signed speeds and curvature
    localparam int LIM_W  = 31;              // unsigned limit registers
    localparam int PER_W  = PERIOD_BITS;     // tick period, Q0.16
    localparam int PROD_W = 64;              // shared multiplier product
    localparam int WIN_W  = SPD_W + 2;       // slew window, last +/- step

    // iterative divide / root unit
    localparam int DATA_W      = 64;
    localparam int DIV_W       = LIM_W + FRAC_BITS;   // dividend width
    localparam int DIV_SHIFT   = DATA_W - DIV_W;
    localparam int SQRT_STEPS  = DATA_W / 2;
    localparam int REM_W       = 36;
    localparam int ITER_MAX    = (DIV_W > SQRT_STEPS) ? DIV_W : SQRT_STEPS;
    localparam int CNT_W       = $clog2(ITER_MAX + 1);

    // quotient at or above this saturates the centripetal bound
    localparam logic [DATA_W-1:0] SAT_Q = DATA_W'(1) << (62 - FRAC_BITS);
    localparam logic [LIM_W-1:0]  LIM_MAX = {LIM_W{1'b1}};

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_SPEED_MAX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_SPEED_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_ACCEL_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_ACCEL_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRIPETAL_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD     = 3'd5;

    // operations of the iterative unit
    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } iter_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/sacl_iter.sv =====
// Shared shift-subtract unit: restoring divide and bitwise integer square root.
`default_nettype none

module sacl_iter
    import sacl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iter_req_t         req,
    input  wire logic [DATA_W-1:0] din,
    input  wire logic [SPD_W-1:0]  divisor,
    output iter_rsp_t              rsp,
    output logic [DATA_W-1:0]      result
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              op_reg;
    logic [REM_W-1:0]  acc_reg;
    logic [DATA_W-1:0] work_reg;
    logic [DATA_W-1:0] res_reg;
    logic [SPD_W-1:0]  div_reg;

    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              ge;
    logic [DATA_W-1:0] work_shift;

    // one shared subtractor serves both operations
    always_comb
    begin
        if (op_reg == OP_DIV)
        begin
            cand       = {acc_reg[REM_W-2:0], work_reg[DATA_W-1]};
            trial      = {{(REM_W-SPD_W){1'b0}}, div_reg};
            work_shift = {work_reg[DATA_W-2:0], 1'b0};
        end
        else
        begin
            cand       = {acc_reg[REM_W-3:0], work_reg[DATA_W-1:DATA_W-2]};
            trial      = {res_reg[REM_W-3:0], 2'b01};
            work_shift = {work_reg[DATA_W-3:0], 2'b00};
        end
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = ~diff[REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= (req.op == OP_DIV) ? CNT_W'(DIV_W) : CNT_W'(SQRT_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg   <= req.op;
            acc_reg  <= '0;
            res_reg  <= '0;
            div_reg  <= divisor;
            work_reg <= (req.op == OP_DIV) ? (din << DIV_SHIFT) : din;
        end
        else if (busy_reg)
        begin
            acc_reg  <= ge ? diff[REM_W-1:0] : cand;
            res_reg  <= {res_reg[DATA_W-2:0], ge};
            work_reg <= work_shift;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/speed_accel_curvature_limiter.sv =====
// Top level of the speed, acceleration and centripetal limiter.
`default_nettype none

// Each transfer on the input channel is one control tick. A limit request
// (req_type 0) slews the linear and angular speed toward the request by at
// most accel * tick_period from the last result, clamps each to its maximum,
// and, when curve_limit_on is set and curvature is nonzero, clamps linear
// speed to sqrt(centripetal_max / |curvature|) and sets angular speed to
// curvature * |linear speed|, saturated to 32 bits. A preset request
// (req_type 1) loads the two input speeds into the stored state unchanged
// and returns them. All speeds are signed Q16.16. One item is in work at a
// time and in_ready is low until it finishes. A curve-limited tick runs the
// shared shift-subtract unit for 31 + FRAC_BITS divide steps followed by 32
// root steps, the root being skipped when the quotient saturates, plus the
// sequencer steps around it. The finished result sits in an output register,
// so the next item may enter while it waits; the block holds in its last
// step only if that register is still full and not being read. Configuration
// writes are always taken (cfg_ready high) and must come only while the
// block is idle; indexes beyond the register list are dropped.

module speed_accel_curvature_limiter
    import sacl_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [SPD_W-1:0]        cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    req_type,
    input  wire logic signed [SPD_W-1:0] lin_speed_in,
    input  wire logic signed [SPD_W-1:0] ang_speed_in,
    input  wire logic signed [SPD_W-1:0] curvature,
    input  wire logic                    curve_limit_on,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [SPD_W-1:0]      lin_speed_out,
    output logic signed [SPD_W-1:0]      ang_speed_out
);

    // sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] S_MUL_L     = 4'd1;
    localparam logic [ST_W-1:0] S_SLEW_L    = 4'd2;
    localparam logic [ST_W-1:0] S_MUL_A     = 4'd3;
    localparam logic [ST_W-1:0] S_SLEW_A    = 4'd4;
    localparam logic [ST_W-1:0] S_DIV_GO    = 4'd5;
    localparam logic [ST_W-1:0] S_DIV_WAIT  = 4'd6;
    localparam logic [ST_W-1:0] S_SQRT_GO   = 4'd7;
    localparam logic [ST_W-1:0] S_SQRT_WAIT = 4'd8;
    localparam logic [ST_W-1:0] S_CLAMP     = 4'd9;
    localparam logic [ST_W-1:0] S_MUL_K     = 4'd10;
    localparam logic [ST_W-1:0] S_ANG       = 4'd11;
    localparam logic [ST_W-1:0] S_DONE      = 4'd12;

    localparam int BND_W = LIM_W + 2;

    // configuration registers
    logic [LIM_W-1:0] lin_speed_max_reg;
    logic [LIM_W-1:0] ang_speed_max_reg;
    logic [LIM_W-1:0] lin_accel_max_reg;
    logic [LIM_W-1:0] ang_accel_max_reg;
    logic [LIM_W-1:0] centripetal_max_reg;
    logic [PER_W-1:0] tick_period_reg;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    // item being worked on
    logic signed [SPD_W-1:0] lin_in_reg;
    logic signed [SPD_W-1:0] ang_in_reg;
    logic signed [SPD_W-1:0] curv_reg;
    logic                    curve_on_reg;
    logic signed [SPD_W-1:0] v_reg;
    logic signed [SPD_W-1:0] w_reg;
    logic [LIM_W-1:0]        bound_reg;
    logic [LIM_W-1:0]        vmag_reg;
    logic [PROD_W-1:0]       prod_reg;

    // stored state and output register
    logic signed [SPD_W-1:0] last_lin_reg;
    logic signed [SPD_W-1:0] last_ang_reg;
    logic                    out_valid_reg;
    logic signed [SPD_W-1:0] lin_out_reg;
    logic signed [SPD_W-1:0] ang_out_reg;

    logic in_xfer;
    logic out_free;

    // shared multiplier
    logic [SPD_W-1:0] mul_a;
    logic [SPD_W-1:0] mul_b;
    logic [SPD_W-1:0] kmag;

    // slew and clamp datapath
    logic signed [SPD_W-1:0] sl_req;
    logic signed [SPD_W-1:0] sl_last;
    logic [LIM_W-1:0]        sl_vmax;
    logic signed [WIN_W-1:0] sl_req_w;
    logic signed [WIN_W-1:0] sl_lo;
    logic signed [WIN_W-1:0] sl_hi;
    logic signed [WIN_W-1:0] sl_vmax_w;
    logic signed [WIN_W-1:0] sl_win;
    logic signed [WIN_W-1:0] sl_res;
    logic signed [WIN_W-1:0] sl_step;

    // centripetal datapath
    logic signed [BND_W-1:0] v_w;
    logic signed [BND_W-1:0] bnd_w;
    logic signed [BND_W-1:0] v_clamp;
    logic [BND_W-1:0]        v_abs;
    logic [PROD_W-1:0]       prod_k;
    logic signed [SPD_W-1:0] w_curve;

    // iterative unit
    iter_req_t         iter_req;
    iter_rsp_t         iter_rsp;
    logic [DATA_W-1:0] iter_din;
    logic [DATA_W-1:0] iter_res;
    logic [DIV_W-1:0]  quot;
    logic              quot_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign lin_speed_out = lin_out_reg;
    assign ang_speed_out = ang_out_reg;

    // |curvature|; the most negative value maps to 2^31 as unsigned
    assign kmag = curv_reg[SPD_W-1] ? (~curv_reg + SPD_W'(1)) : curv_reg;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_speed_max_reg   <= LIM_W'(65536);
            ang_speed_max_reg   <= LIM_W'(196608);
            lin_accel_max_reg   <= LIM_W'(65536);
            ang_accel_max_reg   <= LIM_W'(196608);
            centripetal_max_reg <= LIM_W'(65536);
            tick_period_reg     <= PER_W'(328);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LIN_SPEED_MAX:   lin_speed_max_reg   <= cfg_data[LIM_W-1:0];
                REG_ANG_SPEED_MAX:   ang_speed_max_reg   <= cfg_data[LIM_W-1:0];
                REG_LIN_ACCEL_MAX:   lin_accel_max_reg   <= cfg_data[LIM_W-1:0];
                REG_ANG_ACCEL_MAX:   ang_accel_max_reg   <= cfg_data[LIM_W-1:0];
                REG_CENTRIPETAL_MAX: centripetal_max_reg <= cfg_data[LIM_W-1:0];
                REG_TICK_PERIOD:     tick_period_reg     <= cfg_data[PER_W-1:0];
                default:             ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Multiplier operand select: step sizes, then |curvature| * |v|
    // ---------------------------------------------------------------
    always_comb
    begin
        unique case (state_reg)
            S_MUL_L:
            begin
                mul_a = {1'b0, lin_accel_max_reg};
                mul_b = {{(SPD_W-PER_W){1'b0}}, tick_period_reg};
            end
            S_MUL_A:
            begin
                mul_a = {1'b0, ang_accel_max_reg};
                mul_b = {{(SPD_W-PER_W){1'b0}}, tick_period_reg};
            end
            S_MUL_K:
            begin
                mul_a = kmag;
                mul_b = {1'b0, vmag_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Slew window and speed clamp, shared by both speeds. The step is
    // the registered product shifted down by the period's fraction bits.
    // ---------------------------------------------------------------
    always_comb
    begin
        if (state_reg == S_SLEW_A)
        begin
            sl_req  = ang_in_reg;
            sl_last = last_ang_reg;
            sl_vmax = ang_speed_max_reg;
        end
        else
        begin
            sl_req  = lin_in_reg;
            sl_last = last_lin_reg;
            sl_vmax = lin_speed_max_reg;
        end

        sl_step   = $signed({3'b000, prod_reg[PER_W +: LIM_W]});
        sl_req_w  = WIN_W'(sl_req);
        sl_lo     = WIN_W'(sl_last) - sl_step;
        sl_hi     = WIN_W'(sl_last) + sl_step;
        sl_vmax_w = $signed({3'b000, sl_vmax});

        if (sl_req_w < sl_lo)
            sl_win = sl_lo;
        else if (sl_req_w > sl_hi)
            sl_win = sl_hi;
        else
            sl_win = sl_req_w;

        if (sl_win < -sl_vmax_w)
            sl_res = -sl_vmax_w;
        else if (sl_win > sl_vmax_w)
            sl_res = sl_vmax_w;
        else
            sl_res = sl_win;
    end

    // ---------------------------------------------------------------
    // Centripetal clamp and angular speed from curvature
    // ---------------------------------------------------------------
    always_comb
    begin
        v_w   = BND_W'(v_reg);
        bnd_w = $signed({2'b00, bound_reg});

        if (v_w < -bnd_w)
            v_clamp = -bnd_w;
        else if (v_w > bnd_w)
            v_clamp = bnd_w;
        else
            v_clamp = v_w;

        v_abs = v_clamp[BND_W-1] ? BND_W'(-v_clamp) : BND_W'(v_clamp);

        // truncate toward zero on the magnitude, then apply the sign
        prod_k = prod_reg >> FRAC_BITS;
        if (curv_reg[SPD_W-1])
        begin
            if (prod_k > PROD_W'(64'h8000_0000))
                w_curve = $signed({1'b1, {(SPD_W-1){1'b0}}});
            else
                w_curve = $signed(-prod_k[SPD_W-1:0]);
        end
        else
        begin
            if (prod_k > PROD_W'(64'h7FFF_FFFF))
                w_curve = $signed({1'b0, {(SPD_W-1){1'b1}}});
            else
                w_curve = $signed(prod_k[SPD_W-1:0]);
        end
    end

    // ---------------------------------------------------------------
    // Divide and root requests
    // ---------------------------------------------------------------
    assign quot     = iter_res[DIV_W-1:0];
    assign quot_sat = ({{(DATA_W-DIV_W){1'b0}}, quot} >= SAT_Q);

    always_comb
    begin
        iter_req.start = (state_reg == S_DIV_GO) || (state_reg == S_SQRT_GO);
        iter_req.op    = (state_reg == S_SQRT_GO) ? OP_SQRT : OP_DIV;
        if (state_reg == S_SQRT_GO)
            iter_din = {{(DATA_W-DIV_W){1'b0}}, quot} << FRAC_BITS;
        else
            iter_din = {{(DATA_W-DIV_W){1'b0}}, centripetal_max_reg,
                        {FRAC_BITS{1'b0}}};
    end

    sacl_iter u_iter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (iter_req),
        .din     (iter_din),
        .divisor (kmag),
        .rsp     (iter_rsp),
        .result  (iter_res)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = req_type ? S_DONE : S_MUL_L;
            end
            S_MUL_L:  state_next = S_SLEW_L;
            S_SLEW_L: state_next = S_MUL_A;
            S_MUL_A:  state_next = S_SLEW_A;
            S_SLEW_A:
            begin
                if (curve_on_reg && (curv_reg != '0))
                    state_next = S_DIV_GO;
                else
                    state_next = S_DONE;
            end
            S_DIV_GO: state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (iter_rsp.done)
                    state_next = quot_sat ? S_CLAMP : S_SQRT_GO;
            end
            S_SQRT_GO: state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:
            begin
                if (iter_rsp.done)
                    state_next = S_CLAMP;
            end
            S_CLAMP: state_next = S_MUL_K;
            S_MUL_K: state_next = S_ANG;
            S_ANG:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state, stored speeds and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_lin_reg  <= '0;
            last_ang_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                last_lin_reg  <= v_reg;
                last_ang_reg  <= w_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            lin_in_reg   <= lin_speed_in;
            ang_in_reg   <= ang_speed_in;
            curv_reg     <= curvature;
            curve_on_reg <= curve_limit_on;
            // a preset passes the measured speeds straight through
            v_reg        <= lin_speed_in;
            w_reg        <= ang_speed_in;
        end

        if ((state_reg == S_MUL_L) || (state_reg == S_MUL_A) || (state_reg == S_MUL_K))
            prod_reg <= mul_a * mul_b;

        if (state_reg == S_SLEW_L)
            v_reg <= sl_res[SPD_W-1:0];
        if (state_reg == S_SLEW_A)
            w_reg <= sl_res[SPD_W-1:0];

        if ((state_reg == S_DIV_WAIT) && iter_rsp.done && quot_sat)
            bound_reg <= LIM_MAX;
        if ((state_reg == S_SQRT_WAIT) && iter_rsp.done)
            bound_reg <= iter_res[LIM_W-1:0];

        if (state_reg == S_CLAMP)
        begin
            v_reg    <= v_clamp[SPD_W-1:0];
            vmag_reg <= v_abs[LIM_W-1:0];
        end

        if (state_reg == S_ANG)
            w_reg <= w_curve;

        if ((state_reg == S_DONE) && out_free)
        begin
            lin_out_reg <= v_reg;
            ang_out_reg <= w_reg;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_speed_accel_curvature_limiter.sv =====
// Self-checking testbench of the speed, acceleration and centripetal limiter.
`timescale 1ns / 100ps

module tb_speed_accel_curvature_limiter;
    import sacl_pkg::*;

    // Request kinds carried on req_type
    localparam logic REQ_LIMIT  = 1'b0;
    localparam logic REQ_PRESET = 1'b1;

    // Register indexes past the end of the list; the block drops these writes
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Settling time after the last result, with margin past a curve-limited tick
    localparam int SETTLE_CYCLES     = 150;
    localparam int SETTING_COUNT     = 8;
    localparam int TICKS_PER_SETTING = 118;
    localparam int TIMEOUT_NS        = 20_000_000;

    // Receiver stall patterns, each held in turn
    typedef enum logic [1:0] {
        READY_ALWAYS = 2'd0,
        READY_SPARSE = 2'd1,
        READY_COIN   = 2'd2,
        READY_WINDOW = 2'd3
    } stall_mode_e;

    typedef struct packed {
        logic signed [SPD_W-1:0] lin;
        logic signed [SPD_W-1:0] ang;
    } speed_pair_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [SPD_W-1:0]        cfg_data  = '0;

    logic                    in_valid       = 1'b0;
    logic                    in_ready;
    logic                    req_type       = REQ_LIMIT;
    logic signed [SPD_W-1:0] lin_speed_in   = '0;
    logic signed [SPD_W-1:0] ang_speed_in   = '0;
    logic signed [SPD_W-1:0] curvature      = '0;
    logic                    curve_limit_on = 1'b0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [SPD_W-1:0] lin_speed_out;
    logic signed [SPD_W-1:0] ang_speed_out;

    // Shadow copy of the limit registers, at their reset values
    logic [LIM_W-1:0] cfg_lin_max     = 31'd65536;
    logic [LIM_W-1:0] cfg_ang_max     = 31'd196608;
    logic [LIM_W-1:0] cfg_lin_accel   = 31'd65536;
    logic [LIM_W-1:0] cfg_ang_accel   = 31'd196608;
    logic [LIM_W-1:0] cfg_centripetal = 31'd65536;
    logic [PER_W-1:0] cfg_period      = 16'd328;

    // Last constrained speeds, the slew origin of the next tick
    logic signed [SPD_W-1:0] last_lin = '0;
    logic signed [SPD_W-1:0] last_ang = '0;

    // Speeds still owed by the block, oldest first
    speed_pair_t pending_speeds[$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int ticks_sent      = 0;
    int presets_sent    = 0;
    int curve_ticks     = 0;
    int settings_loaded = 0;
    int burst_left      = 0;

    logic [9:0] stall_clock = '0;

    speed_accel_curvature_limiter dut (
        .clk, .rst_n,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .req_type, .lin_speed_in, .ang_speed_in,
        .curvature, .curve_limit_on,
        .out_valid, .out_ready, .lin_speed_out, .ang_speed_out
    );

    always #10 clk = ~clk;

    // Slew toward the request by at most accel * period, then clamp to +/- vmax
    function automatic longint slew_limit(input longint target, input longint prev,
                                          input logic [LIM_W-1:0] accel,
                                          input logic [LIM_W-1:0] vmax);
        longint step;
        longint vlim;
        longint v;
        step = (64'(accel) * 64'(cfg_period)) >> PERIOD_BITS;
        vlim = vmax;
        v = target;
        if (v < prev - step)
            v = prev - step;
        if (v > prev + step)
            v = prev + step;
        if (v < -vlim)
            v = -vlim;
        if (v > vlim)
            v = vlim;
        return v;
    endfunction

    // Work out the speeds of one tick and advance the stored state
    function automatic speed_pair_t predict_tick(input logic kind,
                                                 input logic signed [SPD_W-1:0] lin_req,
                                                 input logic signed [SPD_W-1:0] ang_req,
                                                 input logic signed [SPD_W-1:0] curv,
                                                 input logic curve_on);
        speed_pair_t       r;
        longint            v;
        longint            w;
        longint            k;
        longint            bound;
        longint unsigned   kmag;
        longint unsigned   q;
        longint unsigned   rem;
        longint unsigned   root;
        longint unsigned   bit_w;
        longint unsigned   vmag;
        longint unsigned   prod;
        if (kind == REQ_PRESET)
        begin
            v = lin_req;
            w = ang_req;
        end
        else
        begin
            v = slew_limit(lin_req, last_lin, cfg_lin_accel, cfg_lin_max);
            w = slew_limit(ang_req, last_ang, cfg_ang_accel, cfg_ang_max);
            if (curve_on && curv != 0)
            begin
                // most negative curvature keeps its full 2^31 magnitude
                k = curv;
                if (k < 0)
                    k = -k;
                kmag = k;
                q = (64'(cfg_centripetal) << FRAC_BITS) / kmag;
                if (q >= (64'd1 << (62 - FRAC_BITS)))
                begin
                    bound = 64'h7FFF_FFFF;
                end
                else
                begin
                    // bitwise integer square root of q << F
                    rem   = q << FRAC_BITS;
                    root  = 0;
                    bit_w = 64'd1 << 62;
                    while (bit_w > rem)
                        bit_w = bit_w >> 2;
                    while (bit_w != 0)
                    begin
                        if (rem >= root + bit_w)
                        begin
                            rem  = rem - (root + bit_w);
                            root = (root >> 1) + bit_w;
                        end
                        else
                        begin
                            root = root >> 1;
                        end
                        bit_w = bit_w >> 2;
                    end
                    bound = root;
                end
                if (v > bound)
                    v = bound;
                else if (v < -bound)
                    v = -bound;
                vmag = (v < 0) ? -v : v;
                prod = (kmag * vmag) >> FRAC_BITS;
                // angular speed takes the sign of curvature, saturated to 32 bits
                if (curv < 0)
                begin
                    if (prod > 64'h8000_0000)
                        prod = 64'h8000_0000;
                    w = prod;
                    w = -w;
                end
                else
                begin
                    if (prod > 64'h7FFF_FFFF)
                        prod = 64'h7FFF_FFFF;
                    w = prod;
                end
            end
        end
        last_lin = v[SPD_W-1:0];
        last_ang = w[SPD_W-1:0];
        r.lin = v[SPD_W-1:0];
        r.ang = w[SPD_W-1:0];
        return r;
    endfunction

    // Request speed: mostly within reach of the limit, sometimes anywhere
    function automatic logic [SPD_W-1:0] pick_speed(input logic [LIM_W-1:0] limit);
        longint span;
        longint mag;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    3: return {1'b0, limit};
                    default: return -{1'b0, limit};
                endcase
            end
            default:
            begin
                span = limit;
                span = span * 2 + 1024;
                if (span > 64'sh7FFF_FFFF)
                    span = 64'sh7FFF_FFFF;
                mag = {$urandom} % (span + 1);
                if ($urandom_range(0, 1) != 0)
                    mag = -mag;
                return mag[SPD_W-1:0];
            end
        endcase
    endfunction

    // Curvature: mostly a gentle bend, with straight, extreme and wild values
    function automatic logic [SPD_W-1:0] pick_curvature();
        logic [SPD_W-1:0] c;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                c = $urandom_range(1, 32'h0004_0000);
                return ($urandom_range(0, 1) != 0) ? -c : c;
            end
        endcase
    endfunction

    // Limit register value: zero, full scale, raw noise or a typical value
    function automatic logic [SPD_W-1:0] pick_limit(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic logic [SPD_W-1:0] pick_period();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'h0000_FFFF;
            2: return 32'd1;
            3: return $urandom;
            default: return $urandom_range(100, 6600);
        endcase
    endfunction

    // One register transfer; leaves cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LIN_SPEED_MAX:   cfg_lin_max     = data[LIM_W-1:0];
            REG_ANG_SPEED_MAX:   cfg_ang_max     = data[LIM_W-1:0];
            REG_LIN_ACCEL_MAX:   cfg_lin_accel   = data[LIM_W-1:0];
            REG_ANG_ACCEL_MAX:   cfg_ang_accel   = data[LIM_W-1:0];
            REG_CENTRIPETAL_MAX: cfg_centripetal = data[LIM_W-1:0];
            REG_TICK_PERIOD:     cfg_period      = data[PER_W-1:0];
            default: ;
        endcase
    endtask

    // Write every register, then poke one spare index the block must ignore
    task automatic load_settings(input logic [SPD_W-1:0] lin_max, input logic [SPD_W-1:0] ang_max,
                                 input logic [SPD_W-1:0] lin_acc, input logic [SPD_W-1:0] ang_acc,
                                 input logic [SPD_W-1:0] cent, input logic [SPD_W-1:0] period);
        write_reg(REG_LIN_SPEED_MAX, lin_max);
        write_reg(REG_ANG_SPEED_MAX, ang_max);
        write_reg(REG_LIN_ACCEL_MAX, lin_acc);
        write_reg(REG_ANG_ACCEL_MAX, ang_acc);
        write_reg(REG_CENTRIPETAL_MAX, cent);
        write_reg(REG_TICK_PERIOD, period);
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Offer one tick, record its expected speeds on transfer, then pace the
    // sender: keep valid high inside a burst, drop it for a gap between bursts.
    task automatic send_tick(input logic kind, input logic [SPD_W-1:0] lin,
                             input logic [SPD_W-1:0] ang, input logic [SPD_W-1:0] curv,
                             input logic curve_on);
        int gap;
        in_valid       <= 1'b1;
        req_type       <= kind;
        lin_speed_in   <= lin;
        ang_speed_in   <= ang;
        curvature      <= curv;
        curve_limit_on <= curve_on;
        do
            @(posedge clk);
        while (!in_ready);
        pending_speeds.push_back(predict_tick(kind, lin, ang, curv, curve_on));
        ticks_sent++;
        if (kind == REQ_PRESET)
            presets_sent++;
        else if (curve_on && curv != 0)
            curve_ticks++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Hold off until every owed result is back and the block has gone quiet
    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset values: slew, preset, both curvature signs, straight and limit off
    task automatic test_reset_settings();
        send_tick(REQ_LIMIT,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_tick(REQ_PRESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_tick(REQ_LIMIT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_tick(REQ_LIMIT,  32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
        send_tick(REQ_LIMIT,  32'h0002_0000, 32'h0001_0000, 32'h8000_0000, 1'b1);
        send_tick(REQ_LIMIT,  32'hFFFE_0000, 32'h0003_0000, 32'h7FFF_FFFF, 1'b0);
        send_tick(REQ_PRESET, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1);
        send_tick(REQ_LIMIT,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1);
        drain_ticks();
    endtask

    // Every register at full scale: huge steps, saturated bound and angular speed
    task automatic test_full_scale_settings();
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'h0000_FFFF);
        send_tick(REQ_LIMIT,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_tick(REQ_LIMIT,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
        send_tick(REQ_PRESET, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_tick(REQ_LIMIT,  32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
        send_tick(REQ_LIMIT,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_tick(REQ_LIMIT,  32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        drain_ticks();
    endtask

    // Zero limits and a zero period: speeds hold, then clamp to the limits
    task automatic test_zero_settings();
        load_settings('0, '0, '0, '0, '0, '0);
        send_tick(REQ_PRESET, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0000, 1'b0);
        send_tick(REQ_LIMIT,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_tick(REQ_PRESET, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_0000, 1'b0);
        send_tick(REQ_LIMIT,  32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
        drain_ticks();
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h0001_0000, '0);
        send_tick(REQ_PRESET, 32'h0005_0000, 32'hFFFB_0000, 32'h0000_0000, 1'b0);
        send_tick(REQ_LIMIT,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        send_tick(REQ_LIMIT,  32'h8000_0000, 32'h0000_0000, 32'hFFFE_0000, 1'b1);
        drain_ticks();
    endtask

    // Random ticks under a run of settings; the first is a plausible robot
    task automatic test_random_settings();
        int               s;
        int               n;
        logic             kind;
        logic [SPD_W-1:0] curv;
        logic             curve_on;
        for (s = 0; s < SETTING_COUNT; s++)
        begin
            if (s == 0)
                load_settings(32'h0002_0000, 32'h0004_0000, 32'h0008_0000, 32'h0010_0000,
                              32'h0002_0000, 32'd3277);
            else
                load_settings(pick_limit(32'h0000_4000, 32'h0008_0000),
                              pick_limit(32'h0000_4000, 32'h0010_0000),
                              pick_limit(32'h0000_8000, 32'h0040_0000),
                              pick_limit(32'h0000_8000, 32'h0080_0000),
                              pick_limit(32'h0000_4000, 32'h0010_0000),
                              pick_period());
            for (n = 0; n < TICKS_PER_SETTING; n++)
            begin
                kind     = ($urandom_range(0, 19) == 0) ? REQ_PRESET : REQ_LIMIT;
                curv     = pick_curvature();
                curve_on = ($urandom_range(0, 3) != 0);
                send_tick(kind, pick_speed(cfg_lin_max), pick_speed(cfg_ang_max),
                          curv, curve_on);
            end
            drain_ticks();
        end
    endtask

    // Receiver: cycle through stall patterns on a clock of its own
    always @(posedge clk)
    begin
        stall_clock <= stall_clock + 1'b1;
        case (stall_mode_e'(stall_clock[9:8]))
            READY_ALWAYS: out_ready <= 1'b1;
            READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            READY_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
            READY_WINDOW: out_ready <= (stall_clock[4:0] >= 5'd26);
            default:      out_ready <= 1'b1;
        endcase
    end

    // Compare each result transfer with the oldest owed speeds
    always @(posedge clk)
    begin : check_results
        speed_pair_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_speeds.size() == 0)
            begin
                $error("result with no tick pending: lin_speed_out %0d ang_speed_out %0d",
                       lin_speed_out, ang_speed_out);
                mismatch_count++;
            end
            else
            begin
                due = pending_speeds.pop_front();
                if (lin_speed_out !== due.lin)
                begin
                    $error("lin_speed_out: expected %0d, actual %0d", due.lin, lin_speed_out);
                    mismatch_count++;
                end
                if (ang_speed_out !== due.ang)
                begin
                    $error("ang_speed_out: expected %0d, actual %0d", due.ang, ang_speed_out);
                    mismatch_count++;
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_full_scale_settings();
        test_zero_settings();
        test_random_settings();

        $display("Run covered %0d ticks (%0d presets, %0d curve-limited) under %0d settings",
                 ticks_sent, presets_sent, curve_ticks, settings_loaded + 1);
        $display("%0d results compared against predicted speeds", results_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: a stuck handshake ends the run as a failure
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still owed", pending_speeds.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
